### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### sv/c2d_pkg.sv
// ----------------------------------------------------------------------------
// c2d_pkg
// Shared types and constants of the convolution core.
// ----------------------------------------------------------------------------
package c2d_pkg;
   localparam int MAX_WIDTH_DEF   = 64;
   localparam int MAX_KERNEL_DEF  = 5;
   localparam int MAX_FILTERS_DEF = 8;

   localparam logic [1:0] OP_PIXEL  = 2'd0;
   localparam logic [1:0] OP_WEIGHT = 2'd1;
   localparam logic [1:0] OP_BIAS   = 2'd2;

   localparam logic [1:0] REG_WIDTH   = 2'd0;
   localparam logic [1:0] REG_KERNEL  = 2'd1;
   localparam logic [1:0] REG_FILTERS = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BIAS,
      ST_MAC,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic        start;
      logic [5:0]  r0;
      logic [5:0]  c0;
   } job_type;

   typedef struct packed {
      logic [1:0]         op;
      logic               frame_start;
      logic [2:0]         tap_row;
      logic [2:0]         tap_col;
      logic [2:0]         filter_sel;
      logic signed [15:0] sample;
   } req_type;

   typedef struct packed {
      logic [2:0]  out_filter;
      logic [5:0]  out_row;
      logic [5:0]  out_col;
      logic [14:0] activation;
      logic        last;
   } rsp_type;
endpackage

### sv/c2d_if.sv
// ----------------------------------------------------------------------------
// c2d_req_if / c2d_rsp_if
// Valid/ready channels for request and response beats.
// ----------------------------------------------------------------------------
interface c2d_req_if;
   logic             valid;
   logic             ready;
   c2d_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface c2d_rsp_if;
   logic             valid;
   logic             ready;
   c2d_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### sv/c2d_csr.sv
// ----------------------------------------------------------------------------
// c2d_csr
// APB register file: image width, kernel size, filter count, clamped on write.
// ----------------------------------------------------------------------------
module c2d_csr #(
   parameter int MAX_WIDTH   = c2d_pkg::MAX_WIDTH_DEF,
   parameter int MAX_KERNEL  = c2d_pkg::MAX_KERNEL_DEF,
   parameter int MAX_FILTERS = c2d_pkg::MAX_FILTERS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [6:0]  image_width,
   output logic [2:0]  kernel_size,
   output logic [3:0]  filter_count
);
   logic [6:0] width_ff, width_in;
   logic [2:0] kern_ff, kern_in;
   logic [3:0] filt_ff, filt_in;
   logic       wr;

   assign pready = 1'b1;
   assign wr = psel && penable && pwrite;

   always_comb begin
      width_in = width_ff;
      kern_in  = kern_ff;
      filt_in  = filt_ff;
      if (wr) begin
         case (paddr[3:2])
            c2d_pkg::REG_WIDTH: begin
               if (pwdata[6:0] == 7'd0) width_in = 7'd1;
               else if (32'(pwdata[6:0]) > 32'(MAX_WIDTH)) width_in = 7'(MAX_WIDTH);
               else width_in = pwdata[6:0];
            end
            c2d_pkg::REG_KERNEL: begin
               if (pwdata[2:0] == 3'd0) kern_in = 3'd1;
               else if (32'(pwdata[2:0]) > 32'(MAX_KERNEL)) kern_in = 3'(MAX_KERNEL);
               else kern_in = pwdata[2:0];
            end
            c2d_pkg::REG_FILTERS: begin
               if (pwdata[3:0] == 4'd0) filt_in = 4'd1;
               else if (32'(pwdata[3:0]) > 32'(MAX_FILTERS)) filt_in = 4'(MAX_FILTERS);
               else filt_in = pwdata[3:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= (MAX_WIDTH < 64) ? 7'(MAX_WIDTH) : 7'd64;
         kern_ff  <= (MAX_KERNEL < 3) ? 3'(MAX_KERNEL) : 3'd3;
         filt_ff  <= (MAX_FILTERS < 8) ? 4'(MAX_FILTERS) : 4'd8;
      end else begin
         width_ff <= width_in;
         kern_ff  <= kern_in;
         filt_ff  <= filt_in;
      end
   end

   always_comb begin
      case (paddr[3:2])
         c2d_pkg::REG_WIDTH:   prdata = {25'd0, width_ff};
         c2d_pkg::REG_KERNEL:  prdata = {29'd0, kern_ff};
         c2d_pkg::REG_FILTERS: prdata = {28'd0, filt_ff};
         default:              prdata = 32'd0;
      endcase
   end

   assign image_width  = width_ff;
   assign kernel_size  = kern_ff;
   assign filter_count = filt_ff;
endmodule

### sv/c2d_engine.sv
// ----------------------------------------------------------------------------
// c2d_engine
// Window MAC sequencer: row, weight and bias memories, one tap per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module c2d_engine #(
   parameter int MAX_WIDTH   = c2d_pkg::MAX_WIDTH_DEF,
   parameter int MAX_KERNEL  = c2d_pkg::MAX_KERNEL_DEF,
   parameter int MAX_FILTERS = c2d_pkg::MAX_FILTERS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   c2d_req_if.sink      req,
   c2d_rsp_if.source    rsp,
   input  logic [6:0]   image_width,
   input  logic [2:0]   kernel_size,
   input  logic [3:0]   filter_count
);
   localparam int RDEPTH = MAX_KERNEL * MAX_WIDTH;
   localparam int WDEPTH = MAX_FILTERS * MAX_KERNEL * MAX_KERNEL;
   localparam int RA = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;
   localparam int WA = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
   localparam int BA = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
   localparam int SA = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;

   logic [15:0] row_mem [RDEPTH];
   logic [15:0] wt_mem  [WDEPTH];
   logic [15:0] bias_mem[MAX_FILTERS];

   c2d_pkg::state_type state_ff, state_in;
   logic [10:0] prow_ff, prow_in, pcol_ff, pcol_in;
   logic [SA-1:0] pslot_ff, pslot_in;
   logic [SA-1:0] s0_ff, s0_in, rs_ff, rs_in;
   logic [5:0]  r0_ff, r0_in, c0_ff, c0_in;
   logic [3:0]  f_ff, f_in;
   logic [2:0]  kr_ff, kr_in, kc_ff, kc_in;
   logic        rdv_ff;
   logic signed [47:0] acc_ff;
   logic [15:0] px_q, wt_q, bias_q;
   logic        rsp_v_ff, rsp_v_in;
   c2d_pkg::rsp_type rsp_ff, rsp_in;

   logic        bias_go;
   logic        rd_en, w_en, b_en, pix_wr;
   logic [RA-1:0] r_raddr, r_waddr;
   logic [WA-1:0] w_raddr, w_waddr;
   logic [BA-1:0] b_addr;
   logic [10:0] row_c, col_c;
   logic [SA-1:0] slot_c, nslot_c, s0_c;
   logic        win;
   logic [3:0]  kk;
   logic [47:0] rnd;

   assign kk = {1'b0, kernel_size};
   assign req.ready = (state_ff == c2d_pkg::ST_IDLE);
   wire acc_req = req.valid && req.ready;

   always_comb begin
      row_c = req.data.frame_start ? 11'd0 : prow_ff;
      col_c = req.data.frame_start ? 11'd0 : pcol_ff;
      slot_c = req.data.frame_start ? '0 : pslot_ff;
      nslot_c = (32'(slot_c) + 32'd1 >= 32'(MAX_KERNEL)) ? '0 : slot_c + SA'(1);
      s0_c = (32'(slot_c) + 32'd1 >= 32'(kk)) ? SA'(32'(slot_c) + 32'd1 - 32'(kk))
         : SA'(32'(slot_c) + 32'(MAX_KERNEL) + 32'd1 - 32'(kk));
      win = (row_c < 11'(image_width)) && (col_c < 11'(image_width))
         && (row_c + 11'd1 >= 11'(kk)) && (col_c + 11'd1 >= 11'(kk));
      pix_wr = acc_req && (req.data.op == c2d_pkg::OP_PIXEL)
         && (32'(col_c) < MAX_WIDTH);
      r_waddr = RA'(32'(slot_c) * MAX_WIDTH + 32'(col_c));
      w_en = acc_req && (req.data.op == c2d_pkg::OP_WEIGHT)
         && (32'(req.data.tap_row) < MAX_KERNEL) && (32'(req.data.tap_col) < MAX_KERNEL)
         && (32'(req.data.filter_sel) < MAX_FILTERS);
      w_waddr = WA'((32'(req.data.filter_sel) * MAX_KERNEL + 32'(req.data.tap_row))
         * MAX_KERNEL + 32'(req.data.tap_col));
      b_en = acc_req && (req.data.op == c2d_pkg::OP_BIAS)
         && (32'(req.data.filter_sel) < MAX_FILTERS);
      r_raddr = RA'(32'(rs_ff) * MAX_WIDTH + 32'(c0_ff) + 32'(kc_ff));
      w_raddr = WA'((32'(f_ff) * MAX_KERNEL + 32'(kr_ff)) * MAX_KERNEL + 32'(kc_ff));
      b_addr = w_en ? BA'(req.data.filter_sel) : (b_en ? BA'(req.data.filter_sel)
         : BA'(f_ff));
   end

   always_ff @(posedge clock) begin
      if (pix_wr) row_mem[r_waddr] <= req.data.sample;
      if (w_en) wt_mem[w_waddr] <= req.data.sample;
      if (b_en) bias_mem[b_addr] <= req.data.sample;
      px_q   <= row_mem[r_raddr];
      wt_q   <= wt_mem[w_raddr];
      bias_q <= bias_mem[BA'(f_ff)];
   end

   always_comb begin
      state_in = state_ff;
      prow_in = prow_ff; pcol_in = pcol_ff;
      pslot_in = pslot_ff;
      s0_in = s0_ff; rs_in = rs_ff;
      r0_in = r0_ff; c0_in = c0_ff;
      f_in = f_ff; kr_in = kr_ff; kc_in = kc_ff;
      rd_en = 1'b0; bias_go = 1'b0;
      rsp_v_in = rsp_v_ff && !rsp.ready;
      rsp_in = rsp_ff;
      rnd = 48'(acc_ff) + 48'd8192;
      case (state_ff)
         c2d_pkg::ST_IDLE: begin
            if (acc_req && req.data.op == c2d_pkg::OP_PIXEL) begin
               if (col_c + 11'd1 >= 11'(image_width)) begin
                  pcol_in = 11'd0;
                  if (row_c + 11'd1 >= 11'(image_width)) begin
                     prow_in = 11'd0;
                     pslot_in = '0;
                  end else begin
                     prow_in = row_c + 11'd1;
                     pslot_in = nslot_c;
                  end
               end else begin
                  pcol_in = col_c + 11'd1;
                  prow_in = row_c;
                  pslot_in = slot_c;
               end
               if (win) begin
                  r0_in = 6'(row_c + 11'd1 - 11'(kk));
                  c0_in = 6'(col_c + 11'd1 - 11'(kk));
                  s0_in = s0_c; rs_in = s0_c;
                  f_in = 4'd0; kr_in = 3'd0; kc_in = 3'd0;
                  state_in = c2d_pkg::ST_BIAS;
               end
            end
         end
         c2d_pkg::ST_BIAS: begin
            state_in = c2d_pkg::ST_MAC;
         end
         c2d_pkg::ST_MAC: begin
            bias_go = (kr_ff == 3'd0) && (kc_ff == 3'd0);
            rd_en = 1'b1;
            if (kc_ff + 3'd1 >= kernel_size) begin
               kc_in = 3'd0;
               if (kr_ff + 3'd1 >= kernel_size) begin
                  kr_in = 3'd0;
                  rs_in = s0_ff;
                  state_in = c2d_pkg::ST_DRAIN;
               end else begin
                  kr_in = kr_ff + 3'd1;
                  rs_in = (32'(rs_ff) + 32'd1 >= 32'(MAX_KERNEL)) ? '0 : rs_ff + SA'(1);
               end
            end else kc_in = kc_ff + 3'd1;
         end
         c2d_pkg::ST_DRAIN: begin
            state_in = c2d_pkg::ST_EMIT;
         end
         c2d_pkg::ST_EMIT: begin
            if (!rsp_v_ff || rsp.ready) begin
               rsp_v_in = 1'b1;
               rsp_in.out_filter = 3'(f_ff);
               rsp_in.out_row = r0_ff;
               rsp_in.out_col = c0_ff;
               rsp_in.last = (f_ff + 4'd1 == filter_count);
               if (acc_ff < 0) rsp_in.activation = 15'd0;
               else if (|rnd[47:29]) rsp_in.activation = 15'h7fff;
               else rsp_in.activation = rnd[28:14];
               if (f_ff + 4'd1 >= filter_count) state_in = c2d_pkg::ST_IDLE;
               else begin
                  f_in = f_ff + 4'd1;
                  state_in = c2d_pkg::ST_BIAS;
               end
            end
         end
         default: state_in = c2d_pkg::ST_IDLE;
      endcase
   end

   logic bias_pend_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= c2d_pkg::ST_IDLE;
         prow_ff <= 11'd0; pcol_ff <= 11'd0;
         pslot_ff <= '0;
         rsp_v_ff <= 1'b0; rdv_ff <= 1'b0;
         bias_pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         prow_ff <= prow_in; pcol_ff <= pcol_in;
         pslot_ff <= pslot_in;
         rsp_v_ff <= rsp_v_in;
         rdv_ff <= rd_en;
         bias_pend_ff <= bias_go;
      end
   end

   // bias enters on the first product of each filter
   logic signed [31:0] prod;
   assign prod = signed'(px_q) * signed'(wt_q);
   always_ff @(posedge clock) begin
      r0_ff <= r0_in; c0_ff <= c0_in;
      s0_ff <= s0_in; rs_ff <= rs_in;
      f_ff <= f_in; kr_ff <= kr_in; kc_ff <= kc_in;
      rsp_ff <= rsp_in;
      if (rdv_ff) acc_ff <= (bias_pend_ff ? (48'(signed'(bias_q)) <<< 14) : acc_ff)
         + 48'(prod);
   end

   assign rsp.valid = rsp_v_ff;
   assign rsp.data = rsp_ff;

   `ASSERT_IMPLY(a_noacc_busy, clock, reset, state_ff != c2d_pkg::ST_IDLE, !req.ready)
   `ASSERT_NEXT(a_mac_drain, clock, reset, state_ff == c2d_pkg::ST_DRAIN,
      state_ff == c2d_pkg::ST_EMIT)
   `ASSERT_IMPLY(a_flt_rng, clock, reset, rsp.valid, rsp.data.out_filter < filter_count)
endmodule

### sv/conv2d_multi_filter_relu_core.sv
// ----------------------------------------------------------------------------
// conv2d_multi_filter_relu_core
// Valid 2-D convolution with several filters, bias and ReLU.
// ----------------------------------------------------------------------------
// A pixel that completes a window is accepted and then, per active filter,
// runs bias setup, one multiply-accumulate per tap from the row and weight
// memories (one read port each), a drain step and the result beat. The result
// beat waits while the previous beat is not yet taken. req_ready is low while
// a window is being computed.
module conv2d_multi_filter_relu_core #(
   parameter int MAX_WIDTH   = c2d_pkg::MAX_WIDTH_DEF,
   parameter int MAX_KERNEL  = c2d_pkg::MAX_KERNEL_DEF,
   parameter int MAX_FILTERS = c2d_pkg::MAX_FILTERS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   c2d_req_if.sink     req,
   c2d_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [6:0] image_width;
   logic [2:0] kernel_size;
   logic [3:0] filter_count;

   c2d_csr #(.MAX_WIDTH(MAX_WIDTH), .MAX_KERNEL(MAX_KERNEL), .MAX_FILTERS(MAX_FILTERS))
   u_csr (
      .clock, .reset,
      .psel(csr_psel), .penable(csr_penable), .pwrite(csr_pwrite),
      .paddr(csr_paddr), .pwdata(csr_pwdata), .prdata(csr_prdata),
      .pready(csr_pready),
      .image_width, .kernel_size, .filter_count
   );

   c2d_engine #(.MAX_WIDTH(MAX_WIDTH), .MAX_KERNEL(MAX_KERNEL), .MAX_FILTERS(MAX_FILTERS))
   u_engine (
      .clock, .reset, .req, .rsp,
      .image_width, .kernel_size, .filter_count
   );
endmodule
